### src/bsps_pkg.sv
// Shared types and codes for the biphasic stimulation pulse sequencer.
package bsps_pkg;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FWD  = 2'd1,
        PH_REV  = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    // Stimulation mode register codes
    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_SINGLE    = 2'd1,
        MODE_SCAN_ONCE = 2'd2,
        MODE_SCAN_LOOP = 2'd3
    } t_mode;

    // Electrode switch codes
    localparam logic [1:0] POL_SHUNT = 2'd0;
    localparam logic [1:0] POL_FWD   = 2'd1;
    localparam logic [1:0] POL_REV   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PULSE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_GAP_TICKS     = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [2:0] REG_STIM_MODE     = 3'd3;
    localparam logic [2:0] REG_START_CHANNEL = 3'd4;
    localparam logic [2:0] REG_SUPPLY_ON     = 3'd5;

    // Channel codes at or above this skip one multiplexer input
    localparam logic [3:0] REMAP_FIRST_CHANNEL = 4'd13;

    // Result word layout, lowest bit up
    localparam int OUT_POL_LSB  = 0;
    localparam int OUT_CUR_LSB  = 2;
    localparam int OUT_CHAN_LSB = 8;
    localparam int OUT_SUP_BIT  = 12;
    localparam int OUT_HALT_BIT = 13;

endpackage

### src/biphasic_stim_pulse_sequencer_top.sv
// Biphasic stimulation pulse sequencer: tick-driven phase counter and channel scan.
// Latency: a tick item accepted at one edge shows its result on m_axis the next cycle.
// Throughput: one tick item per cycle while m_axis_tready holds; the single output register frees as it is taken.
// The result is worked out in one pass from the tick and the phase/channel registers.
// Reset (i_rst_n low, synchronous): phase idle, counter and channels zero, not halted,
// registers at their defaults (pulse width 1, gap 1, amplitude 0, mode off, supply off).
module biphasic_stim_pulse_sequencer_top #(
    parameter int TICK_COUNT_BITS   = 16,
    parameter int LAST_SCAN_CHANNEL = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] stim_on, [7:1] zero
    input  logic        s_axis_tuser,   // [0] train_start
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] polarity, [7:2] drive_current,
                                        // [11:8] channel_select, [12] supply_enable,
                                        // [13] halted, [15:14] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int LEN_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = {TICK_COUNT_BITS{1'b1}};
    localparam logic [3:0] LAST_CH = 4'(LAST_SCAN_CHANNEL);

    // Configuration registers
    logic [15:0] r_pulse_width;
    logic [15:0] r_gap_ticks;
    logic [5:0]  r_amplitude;
    bsps_pkg::t_mode r_stim_mode;
    logic [3:0]  r_start_channel;
    logic        r_supply_on;

    // Sequencer state
    bsps_pkg::t_phase r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0] r_ticks, n_ticks;
    logic [3:0] r_next_ch, n_next_ch;
    logic [3:0] r_sel_ch, n_sel_ch;
    logic       r_done, n_done;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] n_out_data;

    logic s_xfer;
    logic stim, tstart, active;
    logic [TICK_COUNT_BITS-1:0] pw_len, gap_len, cur_len, tick_inc;
    logic pw_nz, gap_nz;
    bsps_pkg::t_phase run_phase;
    logic [TICK_COUNT_BITS-1:0] run_ticks;
    logic [1:0] o_pol;
    logic [5:0] o_cur;
    logic       o_sup;
    logic [3:0] remap_ch;

    // Clamp a 16-bit phase length to the tick counter range
    function automatic logic [TICK_COUNT_BITS-1:0] sat_len(input logic [15:0] len);
        logic [LEN_W-1:0] wide;
        wide = LEN_W'(len);
        if (wide > LEN_W'(CNT_MAX)) begin
            sat_len = CNT_MAX;
        end else begin
            sat_len = TICK_COUNT_BITS'(wide);
        end
    endfunction

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign stim    = s_axis_tdata[0];
    assign tstart  = s_axis_tuser;
    assign active  = (r_stim_mode != bsps_pkg::MODE_OFF) && !r_done;
    assign pw_len  = sat_len(r_pulse_width);
    assign gap_len = sat_len(r_gap_ticks);
    assign pw_nz   = (r_pulse_width != 16'd0);
    assign gap_nz  = (r_gap_ticks != 16'd0);

    // Channel choice at a train start
    always_comb begin
        n_sel_ch  = r_sel_ch;
        n_next_ch = r_next_ch;
        n_done    = r_done;
        if (active && stim && tstart) begin
            unique case (r_stim_mode)
                bsps_pkg::MODE_SINGLE: begin
                    n_sel_ch = r_start_channel;
                end
                bsps_pkg::MODE_SCAN_ONCE: begin
                    if (r_next_ch >= LAST_CH) begin
                        n_done = 1'b1;
                    end else begin
                        n_sel_ch  = r_next_ch;
                        n_next_ch = r_next_ch + 4'd1;
                    end
                end
                bsps_pkg::MODE_SCAN_LOOP: begin
                    n_sel_ch  = (r_next_ch >= LAST_CH) ? 4'd0 : r_next_ch;
                    n_next_ch = n_sel_ch + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // Phase the tick runs in, after a possible cycle start
    always_comb begin
        run_phase = r_phase;
        run_ticks = r_ticks;
        if (r_phase == bsps_pkg::PH_IDLE && stim) begin
            run_ticks = '0;
            if (pw_nz) begin
                run_phase = bsps_pkg::PH_FWD;
            end else if (gap_nz) begin
                run_phase = bsps_pkg::PH_GAP;
            end else begin
                run_phase = bsps_pkg::PH_IDLE;
            end
        end
        cur_len  = (run_phase == bsps_pkg::PH_GAP) ? gap_len : pw_len;
        tick_inc = run_ticks + TICK_COUNT_BITS'(1);
    end

    // Next state of the phase sequencer
    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        if (!active || n_done) begin
            n_phase = bsps_pkg::PH_IDLE;
            n_ticks = '0;
        end else begin
            n_phase = run_phase;
            n_ticks = run_ticks;
            if (run_phase != bsps_pkg::PH_IDLE) begin
                if (tick_inc >= cur_len) begin
                    n_ticks = '0;
                    unique case (run_phase)
                        bsps_pkg::PH_FWD: n_phase = pw_nz ? bsps_pkg::PH_REV
                                          : (gap_nz ? bsps_pkg::PH_GAP : bsps_pkg::PH_IDLE);
                        bsps_pkg::PH_REV: n_phase = gap_nz ? bsps_pkg::PH_GAP
                                                           : bsps_pkg::PH_IDLE;
                        default:          n_phase = bsps_pkg::PH_IDLE;
                    endcase
                end else begin
                    n_ticks = tick_inc;
                end
            end
        end
    end

    // Result fields for the tick
    always_comb begin
        o_pol = bsps_pkg::POL_SHUNT;
        o_cur = 6'd0;
        o_sup = 1'b0;
        if (active && !n_done) begin
            if (stim || r_phase != bsps_pkg::PH_IDLE) begin
                o_sup = r_supply_on;
            end
            if (run_phase == bsps_pkg::PH_FWD) begin
                o_pol = bsps_pkg::POL_FWD;
                o_cur = r_amplitude;
            end else if (run_phase == bsps_pkg::PH_REV) begin
                o_pol = bsps_pkg::POL_REV;
                o_cur = r_amplitude;
            end
        end
        remap_ch = (n_sel_ch >= bsps_pkg::REMAP_FIRST_CHANNEL) ? n_sel_ch + 4'd1 : n_sel_ch;
        n_out_data = '0;
        n_out_data[bsps_pkg::OUT_POL_LSB +: 2]  = o_pol;
        n_out_data[bsps_pkg::OUT_CUR_LSB +: 6]  = o_cur;
        n_out_data[bsps_pkg::OUT_CHAN_LSB +: 4] = remap_ch;
        n_out_data[bsps_pkg::OUT_SUP_BIT]       = o_sup;
        n_out_data[bsps_pkg::OUT_HALT_BIT]      = n_done;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width   <= 16'd1;
            r_gap_ticks     <= 16'd1;
            r_amplitude     <= 6'd0;
            r_stim_mode     <= bsps_pkg::MODE_OFF;
            r_start_channel <= 4'd0;
            r_supply_on     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsps_pkg::REG_PULSE_WIDTH:   r_pulse_width   <= i_cfg_data;
                bsps_pkg::REG_GAP_TICKS:     r_gap_ticks     <= i_cfg_data;
                bsps_pkg::REG_AMPLITUDE:     r_amplitude     <= i_cfg_data[5:0];
                bsps_pkg::REG_STIM_MODE:     r_stim_mode     <= bsps_pkg::t_mode'(i_cfg_data[1:0]);
                bsps_pkg::REG_START_CHANNEL: r_start_channel <= i_cfg_data[3:0];
                bsps_pkg::REG_SUPPLY_ON:     r_supply_on     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer state, advanced once per tick transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bsps_pkg::PH_IDLE;
            r_ticks   <= '0;
            r_next_ch <= 4'd0;
            r_sel_ch  <= 4'd0;
            r_done    <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_phase  <= n_phase;
                r_ticks  <= n_ticks;
                r_sel_ch <= n_sel_ch;
                r_done   <= n_done;
            end
            // a start channel write also moves the scan to that channel; it does not clear the halt
            if (i_cfg_valid && i_cfg_index == bsps_pkg::REG_START_CHANNEL) begin
                r_next_ch <= i_cfg_data[3:0];
            end else if (s_xfer) begin
                r_next_ch <= n_next_ch;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

### src/bsps_checker.sv
// Port-level checks for the pulse sequencer, bound to the top level.
module bsps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // once halted, every later result stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |=> !m_axis_tvalid || m_axis_tdata[13])
        else $error("halted flag cleared without reset");

    // halted means shunted, no current, supply off
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |->
            m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[12])
        else $error("output active while halted");

    // no current while shunted, and no undefined switch code
    a_shunt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[1:0] != 2'd3 &&
            (m_axis_tdata[1:0] != 2'd0 || m_axis_tdata[7:2] == 6'd0))
        else $error("current driven while shunted or bad polarity");

endmodule

bind biphasic_stim_pulse_sequencer_top bsps_checker u_bsps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
